FILE: rtl/core/rvd_pkg.sv
package rvd_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 6;
  localparam int CAT_W  = 2;
  localparam int REG_W  = 5;

  // Major opcodes.
  localparam logic [6:0] OPC_MASK     = 7'b1111111;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [WORD_W-1:0] U_MASK      = 32'hFFFFF000;
  localparam logic [WORD_W-1:0] WORD_ECALL  = 32'h00000073;
  localparam logic [WORD_W-1:0] WORD_EBREAK = 32'h00100073;

  // funct3 codes that matter outside the plain tables.
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SRL = 3'd5;
  localparam logic [2:0] F3_SW  = 3'd2;

  // Categories.
  localparam logic [CAT_W-1:0] CAT_INT = 2'd0;
  localparam logic [CAT_W-1:0] CAT_CTL = 2'd1;
  localparam logic [CAT_W-1:0] CAT_MEM = 2'd2;
  localparam logic [CAT_W-1:0] CAT_SYS = 2'd3;

  // Dense operation numbers.
  localparam logic [OP_W-1:0] OP_ADD    = 6'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 6'd1;
  localparam logic [OP_W-1:0] OP_SLL    = 6'd2;
  localparam logic [OP_W-1:0] OP_SLT    = 6'd3;
  localparam logic [OP_W-1:0] OP_SLTU   = 6'd4;
  localparam logic [OP_W-1:0] OP_XOR    = 6'd5;
  localparam logic [OP_W-1:0] OP_SRL    = 6'd6;
  localparam logic [OP_W-1:0] OP_SRA    = 6'd7;
  localparam logic [OP_W-1:0] OP_OR     = 6'd8;
  localparam logic [OP_W-1:0] OP_AND    = 6'd9;
  localparam logic [OP_W-1:0] OP_ADDI   = 6'd10;
  localparam logic [OP_W-1:0] OP_SLTI   = 6'd11;
  localparam logic [OP_W-1:0] OP_SLTIU  = 6'd12;
  localparam logic [OP_W-1:0] OP_XORI   = 6'd13;
  localparam logic [OP_W-1:0] OP_ORI    = 6'd14;
  localparam logic [OP_W-1:0] OP_ANDI   = 6'd15;
  localparam logic [OP_W-1:0] OP_SLLI   = 6'd16;
  localparam logic [OP_W-1:0] OP_SRLI   = 6'd17;
  localparam logic [OP_W-1:0] OP_SRAI   = 6'd18;
  localparam logic [OP_W-1:0] OP_LUI    = 6'd19;
  localparam logic [OP_W-1:0] OP_AUIPC  = 6'd20;
  localparam logic [OP_W-1:0] OP_JAL    = 6'd21;
  localparam logic [OP_W-1:0] OP_JALR   = 6'd22;
  localparam logic [OP_W-1:0] OP_BEQ    = 6'd23;
  localparam logic [OP_W-1:0] OP_BNE    = 6'd24;
  localparam logic [OP_W-1:0] OP_BLT    = 6'd25;
  localparam logic [OP_W-1:0] OP_BGE    = 6'd26;
  localparam logic [OP_W-1:0] OP_BLTU   = 6'd27;
  localparam logic [OP_W-1:0] OP_BGEU   = 6'd28;
  localparam logic [OP_W-1:0] OP_LB     = 6'd29;
  localparam logic [OP_W-1:0] OP_LH     = 6'd30;
  localparam logic [OP_W-1:0] OP_LW     = 6'd31;
  localparam logic [OP_W-1:0] OP_LBU    = 6'd32;
  localparam logic [OP_W-1:0] OP_LHU    = 6'd33;
  localparam logic [OP_W-1:0] OP_SB     = 6'd34;
  localparam logic [OP_W-1:0] OP_SH     = 6'd35;
  localparam logic [OP_W-1:0] OP_SW     = 6'd36;
  localparam logic [OP_W-1:0] OP_FENCE  = 6'd37;
  localparam logic [OP_W-1:0] OP_ECALL  = 6'd38;
  localparam logic [OP_W-1:0] OP_EBREAK = 6'd39;

  typedef struct packed {
    logic              illegal;
    logic [OP_W-1:0]   operation;
    logic [CAT_W-1:0]  category;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src_reg_a;
    logic [REG_W-1:0]  src_reg_b;
    logic [WORD_W-1:0] immediate;
    logic [WORD_W-1:0] raw_word;
  } dec_t;

  // Register-register operations with the base funct7.
  function automatic logic [OP_W-1:0] r_op(input logic [2:0] f3);
    logic [OP_W-1:0] op;
    unique case (f3)
      3'd0: op = OP_ADD;
      3'd1: op = OP_SLL;
      3'd2: op = OP_SLT;
      3'd3: op = OP_SLTU;
      3'd4: op = OP_XOR;
      3'd5: op = OP_SRL;
      3'd6: op = OP_OR;
      default: op = OP_AND;
    endcase
    return op;
  endfunction

  function automatic logic [OP_W-1:0] i_op(input logic [2:0] f3);
    logic [OP_W-1:0] op;
    unique case (f3)
      3'd0: op = OP_ADDI;
      3'd1: op = OP_SLLI;
      3'd2: op = OP_SLTI;
      3'd3: op = OP_SLTIU;
      3'd4: op = OP_XORI;
      3'd5: op = OP_SRLI;
      3'd6: op = OP_ORI;
      default: op = OP_ANDI;
    endcase
    return op;
  endfunction

endpackage

FILE: rtl/core/rvd_instr_if.sv
interface rvd_instr_if;
  import rvd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

FILE: rtl/core/rvd_result_if.sv
interface rvd_result_if;
  import rvd_pkg::*;

  logic              valid;
  logic              ready;
  logic              illegal;
  logic [OP_W-1:0]   operation;
  logic [CAT_W-1:0]  category;
  logic [REG_W-1:0]  dest_reg;
  logic [REG_W-1:0]  src_reg_a;
  logic [REG_W-1:0]  src_reg_b;
  logic [WORD_W-1:0] immediate;
  logic [WORD_W-1:0] raw_word;

  modport source (
    output valid, output illegal, output operation, output category,
    output dest_reg, output src_reg_a, output src_reg_b, output immediate,
    output raw_word, input ready
  );
  modport sink (
    input valid, input illegal, input operation, input category,
    input dest_reg, input src_reg_a, input src_reg_b, input immediate,
    input raw_word, output ready
  );
endinterface

FILE: rtl/core/rv32i_instruction_decoder.sv
// RV32I instruction decoder.
// The instr channel carries one 32-bit instruction word per request; the
// result channel returns one decoded request for each: illegal flag, dense
// operation number, category, rd/rs1/rs2, immediate and a copy of the word.
// Both channels use valid/ready; a request moves when both are high.
// A word is captured in the input register when it is accepted, is decoded
// combinationally from there and lands in the result register as soon as
// that register can take it; the result is offered from there.
// Throughput is one instruction per cycle while the receiver holds ready
// high, set by the two-register pipeline with no loop in the decode logic.
// When the receiver holds ready low, the result register keeps its request
// and the input register fills behind it; the instr channel then takes no
// more words until the result drains. With an empty result register the
// block always accepts a new word.
// Synchronous reset empties both registers; result.valid is low afterwards
// and the block is ready for a word once reset is released.
module rv32i_instruction_decoder (
  input logic         clk,
  input logic         rst,
  rvd_instr_if.sink   instr,
  rvd_result_if.source result
);
  import rvd_pkg::*;

  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic              s2_valid;
  dec_t              s2_res;
  dec_t              dec;
  logic              s1_ready;
  logic              s2_ready;

  assign s2_ready    = !s2_valid || result.ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign instr.ready = s1_ready;

  rvd_decode u_decode (
    .word (s1_word),
    .dec  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && instr.valid) begin
      s1_word <= instr.instr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_res <= dec;
    end
  end

  assign result.valid     = s2_valid;
  assign result.illegal   = s2_res.illegal;
  assign result.operation = s2_res.operation;
  assign result.category  = s2_res.category;
  assign result.dest_reg  = s2_res.dest_reg;
  assign result.src_reg_a = s2_res.src_reg_a;
  assign result.src_reg_b = s2_res.src_reg_b;
  assign result.immediate = s2_res.immediate;
  assign result.raw_word  = s2_res.raw_word;

endmodule

FILE: rtl/core/rvd_decode.sv
module rvd_decode (
  input  logic [rvd_pkg::WORD_W-1:0] word,
  output rvd_pkg::dec_t              dec
);
  import rvd_pkg::*;

  logic [6:0]        opc;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [REG_W-1:0]  rd;
  logic [REG_W-1:0]  rs1;
  logic [REG_W-1:0]  rs2;
  logic [WORD_W-1:0] imm_i;
  logic [WORD_W-1:0] imm_s;
  logic [WORD_W-1:0] imm_b;
  logic [WORD_W-1:0] imm_u;
  logic [WORD_W-1:0] imm_j;
  logic [WORD_W-1:0] shamt;

  logic              bad;
  logic [OP_W-1:0]   op;
  logic [CAT_W-1:0]  cat;
  logic [REG_W-1:0]  use_rd;
  logic [REG_W-1:0]  use_rs1;
  logic [REG_W-1:0]  use_rs2;
  logic [WORD_W-1:0] imm;

  assign opc   = word[6:0] & OPC_MASK;
  assign rd    = word[11:7];
  assign f3    = word[14:12];
  assign rs1   = word[19:15];
  assign rs2   = word[24:20];
  assign f7    = word[31:25];
  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u = word & U_MASK;
  assign imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
  assign shamt = {27'd0, word[24:20]};

  always_comb begin
    bad     = 1'b0;
    op      = OP_ADD;
    cat     = CAT_INT;
    use_rd  = '0;
    use_rs1 = '0;
    use_rs2 = '0;
    imm     = '0;
    unique case (opc)
      OPC_OP: begin
        use_rd  = rd;
        use_rs1 = rs1;
        use_rs2 = rs2;
        if (f7 == F7_BASE) begin
          op = r_op(f3);
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          op = OP_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SRL) begin
          op = OP_SRA;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_OP_IMM: begin
        use_rd  = rd;
        use_rs1 = rs1;
        op      = i_op(f3);
        if (f3 == F3_SLL || f3 == F3_SRL) begin
          imm = shamt;
          if (f7 == F7_ALT && f3 == F3_SRL) begin
            op = OP_SRAI;
          end else if (f7 != F7_BASE) begin
            bad = 1'b1;
          end
        end else begin
          imm = imm_i;
        end
      end
      OPC_LUI: begin
        op     = OP_LUI;
        use_rd = rd;
        imm    = imm_u;
      end
      OPC_AUIPC: begin
        op     = OP_AUIPC;
        use_rd = rd;
        imm    = imm_u;
      end
      OPC_JAL: begin
        op     = OP_JAL;
        cat    = CAT_CTL;
        use_rd = rd;
        imm    = imm_j;
      end
      OPC_JALR: begin
        op      = OP_JALR;
        cat     = CAT_CTL;
        use_rd  = rd;
        use_rs1 = rs1;
        imm     = imm_i;
        bad     = (f3 != F3_ADD);
      end
      OPC_BRANCH: begin
        cat     = CAT_CTL;
        use_rs1 = rs1;
        use_rs2 = rs2;
        imm     = imm_b;
        unique case (f3)
          3'd0: op = OP_BEQ;
          3'd1: op = OP_BNE;
          3'd4: op = OP_BLT;
          3'd5: op = OP_BGE;
          3'd6: op = OP_BLTU;
          3'd7: op = OP_BGEU;
          default: bad = 1'b1;
        endcase
      end
      OPC_LOAD: begin
        cat     = CAT_MEM;
        use_rd  = rd;
        use_rs1 = rs1;
        imm     = imm_i;
        unique case (f3)
          3'd0: op = OP_LB;
          3'd1: op = OP_LH;
          3'd2: op = OP_LW;
          3'd4: op = OP_LBU;
          3'd5: op = OP_LHU;
          default: bad = 1'b1;
        endcase
      end
      OPC_STORE: begin
        cat     = CAT_MEM;
        use_rs1 = rs1;
        use_rs2 = rs2;
        imm     = imm_s;
        op      = OP_SB + {3'd0, f3};
        bad     = (f3 > F3_SW);
      end
      OPC_MISC_MEM: begin
        op  = OP_FENCE;
        cat = CAT_SYS;
        bad = (f3 != F3_ADD);
      end
      OPC_SYSTEM: begin
        cat = CAT_SYS;
        if (word == WORD_ECALL) begin
          op = OP_ECALL;
        end else if (word == WORD_EBREAK) begin
          op = OP_EBREAK;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // An illegal word reports nothing but the flag.
  always_comb begin
    if (bad) begin
      dec         = '0;
      dec.illegal = 1'b1;
    end else begin
      dec.illegal   = 1'b0;
      dec.operation = op;
      dec.category  = cat;
      dec.dest_reg  = use_rd;
      dec.src_reg_a = use_rs1;
      dec.src_reg_b = use_rs2;
      dec.immediate = imm;
      dec.raw_word  = word;
    end
  end

endmodule

FILE: rtl/core/rvd_checker.sv
module rvd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_illegal,
  input logic [rvd_pkg::OP_W-1:0]   out_operation,
  input logic [rvd_pkg::CAT_W-1:0]  out_category,
  input logic [rvd_pkg::REG_W-1:0]  out_dest_reg,
  input logic [rvd_pkg::REG_W-1:0]  out_src_reg_a,
  input logic [rvd_pkg::REG_W-1:0]  out_src_reg_b,
  input logic [rvd_pkg::WORD_W-1:0] out_immediate,
  input logic [rvd_pkg::WORD_W-1:0] out_raw_word
);
  import rvd_pkg::*;

  // Reset leaves no request in the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_raw_word)
      && $stable(out_operation) && $stable(out_illegal))
    else $error("stalled result changed");

  // With the result register empty the input side can never be blocked.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // An illegal word carries nothing besides the flag.
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_illegal |-> out_operation == '0 && out_category == '0
      && out_dest_reg == '0 && out_src_reg_a == '0 && out_src_reg_b == '0
      && out_immediate == '0 && out_raw_word == '0)
    else $error("illegal result has nonzero fields");

  // System operations name no registers and no immediate.
  a_sys_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_illegal && out_category == CAT_SYS |->
      out_operation >= OP_FENCE && out_operation <= OP_EBREAK
      && out_dest_reg == '0 && out_src_reg_a == '0 && out_src_reg_b == '0
      && out_immediate == '0)
    else $error("system result carries register or immediate fields");

endmodule

bind rv32i_instruction_decoder rvd_checker u_rvd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (instr.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_illegal   (result.illegal),
  .out_operation (result.operation),
  .out_category  (result.category),
  .out_dest_reg  (result.dest_reg),
  .out_src_reg_a (result.src_reg_a),
  .out_src_reg_b (result.src_reg_b),
  .out_immediate (result.immediate),
  .out_raw_word  (result.raw_word)
);
